// ===== rtl/poc_pkg.sv =====
package poc_pkg;

    localparam int unsigned CHANNELS    = 8;
    localparam int unsigned SAMPLE_BITS = 12;
    localparam int unsigned FILT_BITS   = 16;
    localparam int unsigned THR_BITS    = 6;
    localparam int unsigned DIS_BITS    = 18;

    localparam logic [THR_BITS-1:0]  NOISE_LEVEL = THR_BITS'(50);
    localparam logic [FILT_BITS-1:0] SIDE_LEVEL  = FILT_BITS'(40 * 16);
    localparam logic [FILT_BITS-1:0] NEAR_LEVEL  = FILT_BITS'(5 * 16);

    typedef struct packed {
        logic above;
        logic band;
        logic quiet;
    } t_lane_stat;

    typedef struct packed {
        logic obstacle;
        logic side;
    } t_flags;

endpackage

// ===== rtl/poc_if.sv =====
interface poc_sweep_if;
    import poc_pkg::*;
    logic                         valid;
    logic                         ready;
    logic [SAMPLE_BITS-1:0]       sample_0;
    logic [SAMPLE_BITS-1:0]       sample_1;
    logic [SAMPLE_BITS-1:0]       sample_2;
    logic [SAMPLE_BITS-1:0]       sample_3;
    logic [SAMPLE_BITS-1:0]       sample_4;
    logic [SAMPLE_BITS-1:0]       sample_5;
    logic [SAMPLE_BITS-1:0]       sample_6;
    logic [SAMPLE_BITS-1:0]       sample_7;
    logic [THR_BITS-1:0]          threshold_lower;
    logic signed [1:0]            side_pref;
    logic                         clear_side_first;

    modport source (
        output valid, sample_0, sample_1, sample_2, sample_3, sample_4, sample_5,
               sample_6, sample_7, threshold_lower, side_pref, clear_side_first,
        input  ready
    );
    modport sink (
        input  valid, sample_0, sample_1, sample_2, sample_3, sample_4, sample_5,
               sample_6, sample_7, threshold_lower, side_pref, clear_side_first,
        output ready
    );
endinterface

interface poc_result_if;
    import poc_pkg::*;
    logic                       valid;
    logic                       ready;
    logic                       obstacle;
    logic                       side_obstacle;
    logic signed [DIS_BITS-1:0] dis_x;
    logic signed [DIS_BITS-1:0] dis_y;
    logic                       turn_dir;

    modport source (
        output valid, obstacle, side_obstacle, dis_x, dis_y, turn_dir,
        input  ready
    );
    modport sink (
        input  valid, obstacle, side_obstacle, dis_x, dis_y, turn_dir,
        output ready
    );
endinterface

// ===== rtl/proximity_obstacle_classifier.sv =====
// An accepted sweep item is held in the lane and flag stage registers, then moves to the output registers.
// Throughput: one item per cycle while the result side takes items.
// The eight filter lanes update their state in the accept cycle; the
// forward and lateral sums are formed from the held distances and registered as the item moves to the output.
// Reset clears all filter, raw, held distance and flag state and empties the pipeline.
module proximity_obstacle_classifier
    import poc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    poc_sweep_if.sink    i_sweep,
    poc_result_if.source o_result
);

    logic [SAMPLE_BITS-1:0] samples [CHANNELS];
    t_lane_stat             stat    [CHANNELS];
    logic [FILT_BITS-1:0]   held    [CHANNELS];
    t_flags                 flags;
    logic                   accept;
    logic                   a_move;

    logic                        r_obst;
    logic                        r_side;
    logic                        r_a_valid;
    logic                        r_out_valid;
    logic                        r_out_obst;
    logic                        r_out_side;
    logic signed [DIS_BITS-1:0]  r_dis_x;
    logic signed [DIS_BITS-1:0]  r_dis_y;
    logic                        r_turn;
    logic signed [DIS_BITS-1:0]  n_dis_x;
    logic signed [DIS_BITS-1:0]  n_dis_y;
    logic                        n_a_valid;
    logic                        n_out_valid;

    assign samples[0] = i_sweep.sample_0;
    assign samples[1] = i_sweep.sample_1;
    assign samples[2] = i_sweep.sample_2;
    assign samples[3] = i_sweep.sample_3;
    assign samples[4] = i_sweep.sample_4;
    assign samples[5] = i_sweep.sample_5;
    assign samples[6] = i_sweep.sample_6;
    assign samples[7] = i_sweep.sample_7;

    assign a_move         = r_a_valid && (!r_out_valid || o_result.ready);
    assign i_sweep.ready  = !r_a_valid || a_move;
    assign accept         = i_sweep.valid && i_sweep.ready;

    for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
        poc_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (accept),
            .i_sample (samples[g]),
            .i_thr    (i_sweep.threshold_lower),
            .o_stat   (stat[g]),
            .o_held   (held[g])
        );
    end

    poc_merge u_merge (
        .i_stat       (stat),
        .i_side_pref  (i_sweep.side_pref),
        .i_clear_side (i_sweep.clear_side_first),
        .i_obst_prev  (r_obst),
        .i_side_prev  (r_side),
        .o_flags      (flags)
    );

    always_comb begin
        n_dis_x = DIS_BITS'(0) - DIS_BITS'(held[0]) - DIS_BITS'(held[1][FILT_BITS-1:1])
                  - DIS_BITS'(held[7][FILT_BITS-1:1]);
        n_dis_y = DIS_BITS'(held[1][FILT_BITS-1:1]) + DIS_BITS'(held[2][FILT_BITS-1:1])
                  + DIS_BITS'(held[3][FILT_BITS-1:1]) - DIS_BITS'(held[5][FILT_BITS-1:1])
                  - DIS_BITS'(held[6][FILT_BITS-1:1]) - DIS_BITS'(held[7][FILT_BITS-1:1]);
        n_a_valid   = accept || (r_a_valid && !a_move);
        n_out_valid = a_move || (r_out_valid && !o_result.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_obst      <= 1'b0;
            r_side      <= 1'b0;
            r_a_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_a_valid   <= n_a_valid;
            r_out_valid <= n_out_valid;
            if (accept) begin
                r_obst <= flags.obstacle;
                r_side <= flags.side;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_move) begin
            r_out_obst <= r_obst;
            r_out_side <= r_side;
            r_dis_x    <= n_dis_x;
            r_dis_y    <= n_dis_y;
            r_turn     <= held[1] > held[7];
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.obstacle      = r_out_obst;
    assign o_result.side_obstacle = r_out_side;
    assign o_result.dis_x         = r_dis_x;
    assign o_result.dis_y         = r_dis_y;
    assign o_result.turn_dir      = r_turn;

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_a_valid)
        else $error("accepted item did not reach the flag stage");

    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && !a_move) |=> (r_a_valid && $stable(r_obst) && $stable(r_side)))
        else $error("stalled flag stage was overwritten");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_result.valid && !r_a_valid))
        else $error("pipeline not empty after reset");

    a_dis_x_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (o_result.dis_x[DIS_BITS-1] || (o_result.dis_x == '0)))
        else $error("forward sum is positive");

endmodule

// ===== rtl/poc_lane.sv =====
module poc_lane
    import poc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic [THR_BITS-1:0]    i_thr,
    output t_lane_stat             o_stat,
    output logic [FILT_BITS-1:0]   o_held
);

    logic [FILT_BITS-1:0]   r_filt;
    logic [SAMPLE_BITS-1:0] r_raw;
    logic [FILT_BITS-1:0]   r_held;
    logic [FILT_BITS-1:0]   n_filt;
    logic [FILT_BITS-1:0]   n_held;
    logic [FILT_BITS+3:0]   scaled;
    logic [FILT_BITS:0]     sum;
    logic [FILT_BITS-1:0]   level;
    logic                   above;
    logic                   band;

    // 14 * y_prev is 16 * y_prev minus 2 * y_prev.
    always_comb begin
        scaled = {r_filt, 4'b0000} - {3'b000, r_filt, 1'b0};
        sum    = {1'b0, scaled[FILT_BITS+3:4]} + (FILT_BITS+1)'(i_sample)
                 + (FILT_BITS+1)'(r_raw);
        n_filt = sum[FILT_BITS-1:0];
        level  = FILT_BITS'({NOISE_LEVEL - i_thr, 4'b0000});
        // A threshold above the noise level makes the level negative.
        above  = (i_thr > NOISE_LEVEL) || (n_filt > level);
        band   = !above && (n_filt > SIDE_LEVEL);
        o_stat.above = above;
        o_stat.band  = band;
        o_stat.quiet = !above && !band;
        if (n_filt < NEAR_LEVEL) begin
            n_held = '0;
        end else if (above) begin
            n_held = n_filt;
        end else begin
            n_held = r_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filt <= '0;
            r_raw  <= '0;
            r_held <= '0;
        end else if (i_en) begin
            r_filt <= n_filt;
            r_raw  <= i_sample;
            r_held <= n_held;
        end
    end

    assign o_held = r_held;

endmodule

// ===== rtl/poc_merge.sv =====
module poc_merge
    import poc_pkg::*;
(
    input  t_lane_stat        i_stat [CHANNELS],
    input  logic signed [1:0] i_side_pref,
    input  logic              i_clear_side,
    input  logic              i_obst_prev,
    input  logic              i_side_prev,
    output t_flags            o_flags
);

    logic en1;
    logic en7;
    logic early_obst;
    logic any_band;
    logic all_quiet;
    logic side_start;

    // Channel 7 comes after every side channel, so only channels 0 and 1 reach the side test.
    always_comb begin
        en1        = i_side_pref[1] || (i_side_pref == 2'sb00);
        en7        = !i_side_pref[1];
        early_obst = i_obst_prev || i_stat[0].above || (en1 && i_stat[1].above);
        any_band   = i_stat[2].band || i_stat[3].band || i_stat[5].band || i_stat[6].band;
        all_quiet  = i_stat[2].quiet && i_stat[3].quiet && i_stat[5].quiet && i_stat[6].quiet;
        side_start = i_clear_side ? 1'b0 : i_side_prev;
        o_flags.obstacle = i_stat[0].above || (en1 && i_stat[1].above)
                           || (en7 && i_stat[7].above);
        if (all_quiet) begin
            o_flags.side = 1'b0;
        end else if (any_band) begin
            o_flags.side = !early_obst;
        end else begin
            o_flags.side = side_start;
        end
    end

endmodule
